@@ rtl/core/mie_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_pkg: shared types and microcode for the modular inverse unit
// Widths, micro-operation codes, jump conditions and the control store.
// ----------------------------------------------------------------------------
package mie_pkg;

    // Operand width of value, modulus and inverse
    localparam int WIDTH = 16;
    // Coefficients are signed and bounded by the modulus; two spare bits
    localparam int CW    = WIDTH + 2;
    // Division step counter
    localparam int CNT_W = $clog2(WIDTH);

    // Micro-program counter
    localparam int PC_W  = 3;
    localparam int OP_W  = 3;
    localparam int CND_W = 3;

    // Datapath operations
    localparam logic [OP_W-1:0] OP_WAIT   = 3'd0;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd1;
    localparam logic [OP_W-1:0] OP_DINIT  = 3'd2;
    localparam logic [OP_W-1:0] OP_DSTEP  = 3'd3;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;
    localparam logic [OP_W-1:0] OP_FIXNEG = 3'd5;
    localparam logic [OP_W-1:0] OP_FINISH = 3'd6;

    // Jump conditions
    localparam logic [CND_W-1:0] CND_NEXT      = 3'd0;
    localparam logic [CND_W-1:0] CND_ALWAYS    = 3'd1;
    localparam logic [CND_W-1:0] CND_NOT_START = 3'd2;
    localparam logic [CND_W-1:0] CND_R1_ZERO   = 3'd3;
    localparam logic [CND_W-1:0] CND_CNT_NZ    = 3'd4;

    // Program addresses
    localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
    localparam logic [PC_W-1:0] PC_TEST   = 3'd1;
    localparam logic [PC_W-1:0] PC_DINIT  = 3'd2;
    localparam logic [PC_W-1:0] PC_DSTEP  = 3'd3;
    localparam logic [PC_W-1:0] PC_UPDATE = 3'd4;
    localparam logic [PC_W-1:0] PC_FIXNEG = 3'd5;
    localparam logic [PC_W-1:0] PC_FINISH = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CND_W-1:0] cond;
        logic [PC_W-1:0]  target;
    } mie_uword_t;

    typedef struct packed {
        logic start;
        logic r1_zero;
        logic cnt_zero;
    } mie_status_t;

    // Control store
    function automatic mie_uword_t mie_rom(input logic [PC_W-1:0] pc);
        mie_uword_t w;
        case (pc)
            PC_WAIT:   w = '{op: OP_WAIT,   cond: CND_NOT_START, target: PC_WAIT};
            PC_TEST:   w = '{op: OP_NOP,    cond: CND_R1_ZERO,   target: PC_FIXNEG};
            PC_DINIT:  w = '{op: OP_DINIT,  cond: CND_NEXT,      target: PC_WAIT};
            PC_DSTEP:  w = '{op: OP_DSTEP,  cond: CND_CNT_NZ,    target: PC_DSTEP};
            PC_UPDATE: w = '{op: OP_UPDATE, cond: CND_ALWAYS,    target: PC_TEST};
            PC_FIXNEG: w = '{op: OP_FIXNEG, cond: CND_NEXT,      target: PC_WAIT};
            PC_FINISH: w = '{op: OP_FINISH, cond: CND_ALWAYS,    target: PC_WAIT};
            default:   w = '{op: OP_NOP,    cond: CND_ALWAYS,    target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/mie_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mie_sequencer: micro-program counter and control store
// Fetch one control word per cycle; advance or jump on datapath status.
// ----------------------------------------------------------------------------
module mie_sequencer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mie_pkg::mie_status_t status,
    output mie_pkg::mie_uword_t  uword
);
    import mie_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign uword = mie_rom(pc_reg);

    always_comb
    begin
        case (uword.cond)
            CND_NEXT:      take = 1'b0;
            CND_ALWAYS:    take = 1'b1;
            CND_NOT_START: take = !status.start;
            CND_R1_ZERO:   take = status.r1_zero;
            CND_CNT_NZ:    take = !status.cnt_zero;
            default:       take = 1'b1;
        endcase
        pc_next = take ? uword.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ rtl/core/modular_inverse_ext_euclid_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_unit: modular inverse by extended Euclid
// Microcoded datapath: restoring divider, coefficient update, final reduce.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  request   in         start & !busy          value, modulus
//  result    out        done (one-cycle pulse)  inverse
//
//  One request at a time. Each Euclid iteration runs the test, the divider
//  set-up, WIDTH restoring division steps and the update; a request is
//  taken in the wait state, runs k such iterations, then the final test,
//  the sign fix and the finish, with at most 23 iterations for 16-bit operands.
//  All iterations share the one bit-serial divider.
//  Reset clears the micro-program counter and the result strobe only.
//  The receiver cannot stall: inverse is valid in the cycle done is high.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mie_pkg::WIDTH-1:0]  value,
    input  logic [mie_pkg::WIDTH-1:0]  modulus,
    output logic                       busy,
    output logic                       done,
    output logic [mie_pkg::WIDTH-1:0]  inverse
);
    import mie_pkg::*;

    mie_uword_t  uword;
    mie_status_t status;

    // Euclid remainders, copy of the modulus
    logic [WIDTH-1:0] r0_reg, r0_next;
    logic [WIDTH-1:0] r1_reg, r1_next;
    logic [WIDTH-1:0] m_reg,  m_next;
    // Coefficients of value, two's complement
    logic [CW-1:0]    c0_reg, c0_next;
    logic [CW-1:0]    c1_reg, c1_next;
    // Divider: partial remainder, running q * c1, step counter
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [CW-1:0]    t_reg,   t_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    // Result
    logic [WIDTH-1:0] inv_reg, inv_next;
    logic             done_reg, done_next;

    // One restoring division step
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH+1:0] trial;
    logic             qbit;
    logic [CW-1:0]    m_ext;
    logic [CW-1:0]    c0_sub;

    mie_sequencer u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword)
    );

    assign status.start    = start;
    assign status.r1_zero  = (r1_reg == '0);
    assign status.cnt_zero = (cnt_reg == '0);

    assign busy    = (uword.op != OP_WAIT);
    assign done    = done_reg;
    assign inverse = inv_reg;

    always_comb
    begin
        // Shift in the next dividend bit and try the subtraction
        rem_sh = {rem_reg, r0_reg[WIDTH-1]};
        trial  = {1'b0, rem_sh} - {2'b00, r1_reg};
        qbit   = !trial[WIDTH+1];
        m_ext  = {2'b00, m_reg};
        c0_sub = c0_reg - m_ext;

        r0_next   = r0_reg;
        r1_next   = r1_reg;
        m_next    = m_reg;
        c0_next   = c0_reg;
        c1_next   = c1_reg;
        rem_next  = rem_reg;
        t_next    = t_reg;
        cnt_next  = cnt_reg;
        inv_next  = inv_reg;
        done_next = 1'b0;

        case (uword.op)
            OP_WAIT:
            begin
                // Take a new request
                if (start)
                begin
                    r0_next = value;
                    r1_next = modulus;
                    m_next  = modulus;
                    c0_next = CW'(1);
                    c1_next = '0;
                end
            end
            OP_DINIT:
            begin
                rem_next = '0;
                t_next   = '0;
                cnt_next = CNT_W'(WIDTH - 1);
            end
            OP_DSTEP:
            begin
                // Quotient bits arrive MSB first: accumulate q * c1 alongside
                rem_next = qbit ? trial[WIDTH-1:0] : rem_sh[WIDTH-1:0];
                r0_next  = {r0_reg[WIDTH-2:0], qbit};
                t_next   = {t_reg[CW-2:0], 1'b0} + (qbit ? c1_reg : '0);
                cnt_next = cnt_reg - 1'b1;
            end
            OP_UPDATE:
            begin
                // Advance the remainder and coefficient pairs
                r0_next = r1_reg;
                r1_next = rem_reg;
                c0_next = c1_reg;
                c1_next = c0_reg - t_reg;
            end
            OP_FIXNEG:
            begin
                if (c0_reg[CW-1])
                begin
                    c0_next = c0_reg + m_ext;
                end
            end
            OP_FINISH:
            begin
                // Coefficient is now in 0..modulus; fold modulus itself to 0
                if (m_reg == '0)
                begin
                    inv_next = '0;
                end
                else if (c0_reg >= m_ext)
                begin
                    inv_next = c0_sub[WIDTH-1:0];
                end
                else
                begin
                    inv_next = c0_reg[WIDTH-1:0];
                end
                done_next = 1'b1;
            end
            default:
            begin
                // hold
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        m_reg   <= m_next;
        c0_reg  <= c0_next;
        c1_reg  <= c1_next;
        rem_reg <= rem_next;
        t_reg   <= t_next;
        cnt_reg <= cnt_next;
        inv_reg <= inv_next;
    end

endmodule
